// ===== sv/ultrasonic_ranger_with_lowpass_defines.svh =====
// Assertion macros for the ultrasonic ranger.
// Expect signals named clock and reset in the module that uses them.
`ifndef ULTRASONIC_RANGER_WITH_LOWPASS_DEFINES_SVH
`define ULTRASONIC_RANGER_WITH_LOWPASS_DEFINES_SVH

// cond implies check in the same cycle
`define ULR_ASSERT_SAME(label, cond, check, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (check)) \
      else $error(msg);

// cond implies check in the next cycle
`define ULR_ASSERT_NEXT(label, cond, check, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (check)) \
      else $error(msg);

`endif

// ===== sv/ulr_pkg.sv =====
// Shared types and constants for the ultrasonic ranger.
// No dependencies.
package ulr_pkg;

   localparam int unsigned TRIGGER_SETTLE_TICKS = 2;
   localparam int unsigned TRIGGER_PULSE_TICKS  = 10;

   localparam int unsigned DATA_W    = 16;
   localparam int unsigned BETA_W    = 9;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned STEP_W    = 4;

   // serial steps: one multiplier bit per cycle
   localparam int unsigned MUL_STEPS   = DATA_W;
   localparam int unsigned BLEND_STEPS = BETA_W;

   localparam logic [DATA_W-1:0] WAIT_LIMIT_RST  = 16'd10000;
   localparam logic [DATA_W-1:0] COUNT_LIMIT_RST = 16'd25000;
   localparam logic [DATA_W-1:0] SCALE_RST       = 16'd1121;
   localparam logic [BETA_W-1:0] BETA_RST        = 9'd64;
   localparam logic [DATA_W-1:0] INIT_DIST_RST   = 16'hFFFF;
   localparam logic [BETA_W-1:0] BETA_FULL       = 9'd256;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_SETTLE = 3'd1,
      PH_PULSE  = 3'd2,
      PH_WAIT   = 3'd3,
      PH_COUNT  = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      SEQ_IDLE  = 3'd0,
      SEQ_SCALE = 3'd1,
      SEQ_SAT   = 3'd2,
      SEQ_BLEND = 3'd3,
      SEQ_FINAL = 3'd4
   } seq_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WAIT_LIMIT  = 3'd0,
      CSR_COUNT_LIMIT = 3'd1,
      CSR_SCALE       = 3'd2,
      CSR_BETA        = 3'd3,
      CSR_INIT_DIST   = 3'd4
   } csr_idx_type;

endpackage

// ===== sv/ultrasonic_ranger_with_lowpass.sv =====
// Ultrasonic ranger: trigger sequencing, echo timing, distance scaling, smoothing.
// Depends on ulr_pkg and ultrasonic_ranger_with_lowpass_defines.svh.
//
// channel | direction | handshake           | payload
// req     | in        | req_valid/req_stall | start_request, echo_level (one tick)
// rsp     | out       | rsp_valid/rsp_stall | trigger, busy, done, timeout, counts
// csr     | in        | csr_write_en        | csr_index, csr_wdata
//
// A tick that does not close a good measurement has its result registered at the accept
// edge. A tick that closes one goes, after the accept cycle, through the bit-serial
// tick*scale multiply, a round-and-saturate step, the bit-serial filter blend and a
// final round. Reset is synchronous and needs no clearing pass.
// A waiting result holds input off only until rsp_stall drops.
`include "ultrasonic_ranger_with_lowpass_defines.svh"

module ultrasonic_ranger_with_lowpass
   import ulr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_start_request,
   input  logic                 req_echo_level,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_trigger_level,
   output logic                 rsp_busy_res,
   output logic                 rsp_done_res,
   output logic                 rsp_timed_out,
   output logic [DATA_W-1:0]    rsp_echo_ticks,
   output logic [DATA_W-1:0]    rsp_raw_distance,
   output logic [DATA_W-1:0]    rsp_filtered_distance,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   // configuration
   logic [DATA_W-1:0] wait_lim_ff, count_lim_ff, scale_ff;
   logic [BETA_W-1:0] beta_ff;

   // measurement state
   phase_type         phase_ff, phase_in;
   logic [DATA_W-1:0] phase_cnt_ff, phase_cnt_in;
   logic [DATA_W-1:0] echo_cnt_ff, echo_cnt_in;
   logic [DATA_W-1:0] last_raw_ff, last_raw_in;
   logic [DATA_W-1:0] smoothed_ff, smoothed_in;

   // arithmetic sequencer
   seq_type           seq_ff, seq_in;
   logic [STEP_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [DATA_W:0]   acc_hi_ff, acc_hi_in;
   logic [DATA_W-1:0] acc_lo_ff, acc_lo_in;
   logic [BETA_W-1:0] wold_ff, wold_in, wnew_ff, wnew_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_trig_ff, rsp_busy_ff, rsp_done_ff, rsp_tout_ff;
   logic [DATA_W-1:0] rsp_ticks_ff, rsp_raw_ff, rsp_filt_ff;
   logic              rsp_load;
   logic              rsp_trig_in, rsp_busy_in, rsp_done_in, rsp_tout_in;
   logic [DATA_W-1:0] rsp_ticks_in, rsp_raw_in, rsp_filt_in;

   // tick step
   logic              accept;
   phase_type         step_ph;
   logic [DATA_W-1:0] step_pc, step_ec, step_inc;
   logic              step_trig, step_busy, step_done, step_tout, step_fin;

   // sequencer strobes
   logic              load_step, do_scale, do_sat, do_blend, do_final;

   // datapath
   logic [DATA_W:0]     scale_sum;
   logic [2*DATA_W-1:0] product;
   logic [22:0]         round_raw;
   logic [DATA_W-1:0]   raw_sat;
   logic [BETA_W-1:0]   beta_eff;
   logic [DATA_W:0]     blend_add;
   logic [DATA_W+1:0]   blend_sum;
   logic [DATA_W+1:0]   blend_round;

   assign accept    = req_valid && !req_stall;
   assign req_stall = !((seq_ff == SEQ_IDLE) && (!rsp_valid_ff || !rsp_stall));

   // ---------------- one tick of the ranging sequence ----------------
   always_comb begin
      case (phase_ff)
         PH_SETTLE, PH_PULSE, PH_WAIT, PH_COUNT: step_ph = phase_ff;
         default:                                step_ph = PH_IDLE;
      endcase
      step_pc   = phase_cnt_ff;
      step_ec   = echo_cnt_ff;
      step_inc  = '0;
      step_trig = 1'b0;
      step_busy = 1'b0;
      step_done = 1'b0;
      step_tout = 1'b0;
      step_fin  = 1'b0;

      if (step_ph == PH_IDLE && req_start_request) begin
         step_ph = PH_SETTLE;
         step_pc = '0;
         step_ec = '0;
      end

      case (step_ph)
         PH_SETTLE: begin
            step_busy = 1'b1;
            step_inc  = step_pc + 1'b1;
            if (step_inc >= DATA_W'(TRIGGER_SETTLE_TICKS)) begin
               step_ph = PH_PULSE;
               step_pc = '0;
            end else begin
               step_pc = step_inc;
            end
         end
         PH_PULSE: begin
            step_busy = 1'b1;
            step_trig = 1'b1;
            step_inc  = step_pc + 1'b1;
            if (step_inc >= DATA_W'(TRIGGER_PULSE_TICKS)) begin
               step_ph = PH_WAIT;
               step_pc = '0;
            end else begin
               step_pc = step_inc;
            end
         end
         PH_WAIT: begin
            step_busy = 1'b1;
            if (req_echo_level) begin
               if (count_lim_ff == '0) begin
                  step_fin  = 1'b1;
                  step_ec   = '0;
                  step_done = 1'b1;
                  step_ph   = PH_IDLE;
               end else if (count_lim_ff == DATA_W'(1)) begin
                  step_fin  = 1'b1;
                  step_ec   = DATA_W'(1);
                  step_done = 1'b1;
                  step_ph   = PH_IDLE;
               end else begin
                  step_ec = DATA_W'(1);
                  step_ph = PH_COUNT;
               end
            end else if (step_pc == wait_lim_ff) begin
               step_ec   = '0;
               step_done = 1'b1;
               step_tout = 1'b1;
               step_ph   = PH_IDLE;
            end else begin
               step_pc = step_pc + 1'b1;
            end
         end
         PH_COUNT: begin
            step_busy = 1'b1;
            if (req_echo_level) begin
               step_inc = step_ec + 1'b1;
               step_ec  = step_inc;
               if (step_inc >= count_lim_ff) begin
                  step_fin  = 1'b1;
                  step_done = 1'b1;
                  step_ph   = PH_IDLE;
               end
            end else begin
               step_fin  = 1'b1;
               step_done = 1'b1;
               step_ph   = PH_IDLE;
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------- sequencer: next state ----------------
   always_comb begin
      seq_in = seq_ff;
      case (seq_ff)
         SEQ_IDLE:  if (accept && step_fin) seq_in = SEQ_SCALE;
         SEQ_SCALE: if (bit_cnt_ff == STEP_W'(MUL_STEPS - 1)) seq_in = SEQ_SAT;
         SEQ_SAT:   seq_in = SEQ_BLEND;
         SEQ_BLEND: if (bit_cnt_ff == STEP_W'(BLEND_STEPS - 1)) seq_in = SEQ_FINAL;
         SEQ_FINAL: seq_in = SEQ_IDLE;
         default:   seq_in = SEQ_IDLE;
      endcase
   end

   // ---------------- sequencer: strobes ----------------
   always_comb begin
      load_step = 1'b0;
      do_scale  = 1'b0;
      do_sat    = 1'b0;
      do_blend  = 1'b0;
      do_final  = 1'b0;
      case (seq_ff)
         SEQ_IDLE:  load_step = accept;
         SEQ_SCALE: do_scale  = 1'b1;
         SEQ_SAT:   do_sat    = 1'b1;
         SEQ_BLEND: do_blend  = 1'b1;
         SEQ_FINAL: do_final  = 1'b1;
         default: begin
         end
      endcase
   end

   // ---------------- datapath ----------------
   always_comb begin
      // shift-and-add, multiplier bits leave acc_lo from the bottom
      scale_sum = {1'b0, acc_hi_ff[DATA_W-1:0]}
                + (acc_lo_ff[0] ? {1'b0, scale_ff} : '0);
      product   = {acc_hi_ff[DATA_W-1:0], acc_lo_ff};
      // (p + 512) >> 10
      round_raw = {1'b0, product[2*DATA_W-1:10]} + 23'(product[9]);
      raw_sat   = (|round_raw[22:DATA_W]) ? '1 : round_raw[DATA_W-1:0];

      beta_eff  = beta_ff[BETA_W-1] ? BETA_FULL : beta_ff;

      // two products summed in one pass: old weight on smoothed, new on raw
      blend_add = (wold_ff[0] ? {1'b0, smoothed_ff} : '0)
                + (wnew_ff[0] ? {1'b0, last_raw_ff} : '0);
      blend_sum = {1'b0, acc_hi_ff} + {1'b0, blend_add};
      // low nine product bits sit in acc_lo[15:7]; (v + 128) >> 8
      blend_round = {acc_hi_ff, acc_lo_ff[DATA_W-1]} + (DATA_W+2)'(acc_lo_ff[DATA_W-2]);

      phase_in     = phase_ff;
      phase_cnt_in = phase_cnt_ff;
      echo_cnt_in  = echo_cnt_ff;
      last_raw_in  = last_raw_ff;
      smoothed_in  = smoothed_ff;
      bit_cnt_in   = bit_cnt_ff;
      acc_hi_in    = acc_hi_ff;
      acc_lo_in    = acc_lo_ff;
      wold_in      = wold_ff;
      wnew_in      = wnew_ff;

      rsp_load     = 1'b0;
      rsp_trig_in  = step_trig;
      rsp_busy_in  = step_busy;
      rsp_done_in  = step_done;
      rsp_tout_in  = step_tout;
      rsp_ticks_in = step_ec;
      rsp_raw_in   = last_raw_ff;
      rsp_filt_in  = smoothed_ff;

      if (load_step) begin
         phase_in     = step_ph;
         phase_cnt_in = step_pc;
         echo_cnt_in  = step_ec;
         acc_hi_in    = '0;
         acc_lo_in    = step_ec;
         bit_cnt_in   = '0;
         rsp_load     = !step_fin;
      end
      if (do_scale) begin
         acc_hi_in  = {1'b0, scale_sum[DATA_W:1]};
         acc_lo_in  = {scale_sum[0], acc_lo_ff[DATA_W-1:1]};
         bit_cnt_in = bit_cnt_ff + 1'b1;
      end
      if (do_sat) begin
         last_raw_in = raw_sat;
         acc_hi_in   = '0;
         acc_lo_in   = '0;
         wnew_in     = beta_eff;
         wold_in     = BETA_FULL - beta_eff;
         bit_cnt_in  = '0;
      end
      if (do_blend) begin
         acc_hi_in  = blend_sum[DATA_W+1:1];
         acc_lo_in  = {blend_sum[0], acc_lo_ff[DATA_W-1:1]};
         wold_in    = wold_ff >> 1;
         wnew_in    = wnew_ff >> 1;
         bit_cnt_in = bit_cnt_ff + 1'b1;
      end
      if (do_final) begin
         smoothed_in  = blend_round[DATA_W-1:0];
         rsp_load     = 1'b1;
         rsp_trig_in  = 1'b0;
         rsp_busy_in  = 1'b1;
         rsp_done_in  = 1'b1;
         rsp_tout_in  = 1'b0;
         rsp_ticks_in = echo_cnt_ff;
         rsp_raw_in   = last_raw_ff;
         rsp_filt_in  = blend_round[DATA_W-1:0];
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         wait_lim_ff  <= WAIT_LIMIT_RST;
         count_lim_ff <= COUNT_LIMIT_RST;
         scale_ff     <= SCALE_RST;
         beta_ff      <= BETA_RST;
         phase_ff     <= PH_IDLE;
         phase_cnt_ff <= '0;
         echo_cnt_ff  <= '0;
         last_raw_ff  <= '0;
         smoothed_ff  <= INIT_DIST_RST;
         seq_ff       <= SEQ_IDLE;
         bit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         phase_cnt_ff <= phase_cnt_in;
         echo_cnt_ff  <= echo_cnt_in;
         last_raw_ff  <= last_raw_in;
         smoothed_ff  <= smoothed_in;
         seq_ff       <= seq_in;
         bit_cnt_ff   <= bit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            case (csr_idx_type'(csr_index))
               CSR_WAIT_LIMIT:  wait_lim_ff  <= csr_wdata;
               CSR_COUNT_LIMIT: count_lim_ff <= csr_wdata;
               CSR_SCALE:       scale_ff     <= csr_wdata;
               CSR_BETA:        beta_ff      <= csr_wdata[BETA_W-1:0];
               // initial distance only matters at reset, which restores its default
               CSR_INIT_DIST: begin
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_hi_ff <= acc_hi_in;
      acc_lo_ff <= acc_lo_in;
      wold_ff   <= wold_in;
      wnew_ff   <= wnew_in;
      if (rsp_load) begin
         rsp_trig_ff  <= rsp_trig_in;
         rsp_busy_ff  <= rsp_busy_in;
         rsp_done_ff  <= rsp_done_in;
         rsp_tout_ff  <= rsp_tout_in;
         rsp_ticks_ff <= rsp_ticks_in;
         rsp_raw_ff   <= rsp_raw_in;
         rsp_filt_ff  <= rsp_filt_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_trigger_level     = rsp_trig_ff;
   assign rsp_busy_res          = rsp_busy_ff;
   assign rsp_done_res          = rsp_done_ff;
   assign rsp_timed_out         = rsp_tout_ff;
   assign rsp_echo_ticks        = rsp_ticks_ff;
   assign rsp_raw_distance      = rsp_raw_ff;
   assign rsp_filtered_distance = rsp_filt_ff;

   // ---------------- assertions ----------------
   `ULR_ASSERT_SAME(a_no_accept_in_math, seq_ff != SEQ_IDLE, req_stall, "tick accepted during arithmetic")
   `ULR_ASSERT_SAME(a_sat_after_scale, seq_ff == SEQ_SAT, ($past(seq_ff) == SEQ_SCALE) && ($past(bit_cnt_ff) == STEP_W'(MUL_STEPS - 1)), "scale multiply cut short")
   `ULR_ASSERT_NEXT(a_final_posts, seq_ff == SEQ_FINAL, rsp_valid_ff && rsp_done_ff, "finished measurement not posted")
   `ULR_ASSERT_SAME(a_tout_with_done, rsp_valid_ff && rsp_tout_ff, rsp_done_ff && rsp_busy_ff && !rsp_trig_ff, "timeout without done")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ultrasonic_ranger_with_lowpass: one tick per transaction,
// a per-tick ranging/filter predictor in a scoreboard class, random idle and stall.
// Depends on ulr_pkg and the ultrasonic_ranger_with_lowpass RTL.
module testbench;
   import ulr_pkg::*;

   localparam int ITEM_TARGET      = 1300;
   localparam int CALM_AFTER       = 1050;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int MAX_PRINTED      = 100;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNUSED = 3'd5;

   typedef struct packed {
      logic              trigger;
      logic              busy;
      logic              done;
      logic              timeout;
      logic [DATA_W-1:0] ticks;
      logic [DATA_W-1:0] raw;
      logic [DATA_W-1:0] filtered;
   } tick_result_type;

   // ranging sequencer + smoothing filter, advanced once per accepted tick
   class ranging_scoreboard;
      phase_type         ph;
      bit [DATA_W-1:0]   ph_cnt, echo_cnt, raw_q, smooth_q;
      bit [DATA_W-1:0]   wait_lim, count_lim, scale, init_dist;
      bit [BETA_W-1:0]   beta;
      tick_result_type   expected_q[$];
      int                errors;

      function new();
         wait_lim  = WAIT_LIMIT_RST;
         count_lim = COUNT_LIMIT_RST;
         scale     = SCALE_RST;
         beta      = BETA_RST;
         init_dist = INIT_DIST_RST;
         ph        = PH_IDLE;
         ph_cnt    = '0;
         echo_cnt  = '0;
         raw_q     = '0;
         smooth_q  = INIT_DIST_RST;
         errors    = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // initial distance only takes effect at reset, so it is just stored
      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
         case (idx)
            CSR_WAIT_LIMIT:  wait_lim  = val;
            CSR_COUNT_LIMIT: count_lim = val;
            CSR_SCALE:       scale     = val;
            CSR_BETA:        beta      = val[BETA_W-1:0];
            CSR_INIT_DIST:   init_dist = val;
            default: ;
         endcase
      endfunction

      function void close_measurement(bit [DATA_W-1:0] count);
         longint unsigned distance, blend, b;
         distance = count;
         distance = (distance * scale + 512) >> 10;
         if (distance > 65535) distance = 65535;
         b = (beta > BETA_FULL) ? BETA_FULL : beta;
         echo_cnt = count;
         raw_q    = distance[DATA_W-1:0];
         blend = ((BETA_FULL - b) * smooth_q + b * raw_q + 128) >> 8;
         smooth_q = blend[DATA_W-1:0];
      endfunction

      function void note_tick(bit start_bit, bit echo_bit);
         tick_result_type r;
         bit [DATA_W-1:0] c;
         r = '0;
         if (ph == PH_IDLE && start_bit) begin
            ph       = PH_SETTLE;
            ph_cnt   = '0;
            echo_cnt = '0;
         end
         case (ph)
            PH_SETTLE: begin
               r.busy = 1'b1;
               ph_cnt = ph_cnt + 1'b1;
               if (ph_cnt >= TRIGGER_SETTLE_TICKS) begin
                  ph     = PH_PULSE;
                  ph_cnt = '0;
               end
            end
            PH_PULSE: begin
               r.busy    = 1'b1;
               r.trigger = 1'b1;
               ph_cnt    = ph_cnt + 1'b1;
               if (ph_cnt >= TRIGGER_PULSE_TICKS) begin
                  ph     = PH_WAIT;
                  ph_cnt = '0;
               end
            end
            PH_WAIT: begin
               r.busy = 1'b1;
               if (echo_bit) begin
                  if (count_lim <= 1) begin
                     // a zero limit closes with a zero count
                     close_measurement(count_lim);
                     r.done = 1'b1;
                     ph     = PH_IDLE;
                  end else begin
                     echo_cnt = 1;
                     ph       = PH_COUNT;
                  end
               end else if (ph_cnt == wait_lim) begin
                  echo_cnt  = '0;
                  r.done    = 1'b1;
                  r.timeout = 1'b1;
                  ph        = PH_IDLE;
               end else begin
                  ph_cnt = ph_cnt + 1'b1;
               end
            end
            PH_COUNT: begin
               r.busy = 1'b1;
               if (echo_bit) begin
                  c = echo_cnt + 1'b1;
                  if (c >= count_lim) begin
                     close_measurement(c);
                     r.done = 1'b1;
                     ph     = PH_IDLE;
                  end else begin
                     echo_cnt = c;
                  end
               end else begin
                  close_measurement(echo_cnt);
                  r.done = 1'b1;
                  ph     = PH_IDLE;
               end
            end
            default: ;
         endcase
         r.ticks    = echo_cnt;
         r.raw      = raw_q;
         r.filtered = smooth_q;
         expected_q.push_back(r);
      endfunction

      task report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
         if (errors < MAX_PRINTED)
            $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
         errors++;
      endtask

      task check_result(tick_result_type got);
         tick_result_type want;
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected transaction", '0, '0);
            return;
         end
         want = expected_q.pop_front();
         if (got.trigger !== want.trigger)
            report_mismatch("trigger_level", DATA_W'(got.trigger), DATA_W'(want.trigger));
         if (got.busy !== want.busy)
            report_mismatch("busy_res", DATA_W'(got.busy), DATA_W'(want.busy));
         if (got.done !== want.done)
            report_mismatch("done_res", DATA_W'(got.done), DATA_W'(want.done));
         if (got.timeout !== want.timeout)
            report_mismatch("timed_out", DATA_W'(got.timeout), DATA_W'(want.timeout));
         if (got.ticks !== want.ticks) report_mismatch("echo_ticks", got.ticks, want.ticks);
         if (got.raw !== want.raw) report_mismatch("raw_distance", got.raw, want.raw);
         if (got.filtered !== want.filtered)
            report_mismatch("filtered_distance", got.filtered, want.filtered);
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_start_request = 1'b0;
   logic                 req_echo_level = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_trigger_level;
   logic                 rsp_busy_res;
   logic                 rsp_done_res;
   logic                 rsp_timed_out;
   logic [DATA_W-1:0]    rsp_echo_ticks;
   logic [DATA_W-1:0]    rsp_raw_distance;
   logic [DATA_W-1:0]    rsp_filtered_distance;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0]    csr_wdata = '0;

   ranging_scoreboard sb = new();
   bit idle_on = 1'b1;
   bit long_hold_req = 1'b0;
   int items_sent = 0;

   ultrasonic_ranger_with_lowpass u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_start_request     (req_start_request),
      .req_echo_level        (req_echo_level),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_trigger_level     (rsp_trigger_level),
      .rsp_busy_res          (rsp_busy_res),
      .rsp_done_res          (rsp_done_res),
      .rsp_timed_out         (rsp_timed_out),
      .rsp_echo_ticks        (rsp_echo_ticks),
      .rsp_raw_distance      (rsp_raw_distance),
      .rsp_filtered_distance (rsp_filtered_distance),
      .csr_write_en          (csr_write_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      tick_result_type got;
      got = {rsp_trigger_level, rsp_busy_res, rsp_done_res, rsp_timed_out,
             rsp_echo_ticks, rsp_raw_distance, rsp_filtered_distance};
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(got);
   end

   // result side: short random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            long_hold_req = 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #4_000_000;
      $display("** ultrasonic_ranger_with_lowpass: FAILED **");
      $finish;
   end

   task automatic send_tick(input bit start_bit, input bit echo_bit);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_start_request <= start_bit;
      req_echo_level    <= echo_bit;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_tick(start_bit, echo_bit);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
   endtask

   task automatic configure(input logic [DATA_W-1:0] wait_val, input logic [DATA_W-1:0] count_val,
                            input logic [DATA_W-1:0] scale_val, input logic [DATA_W-1:0] beta_val,
                            input logic [DATA_W-1:0] dist_val);
      write_reg(CSR_WAIT_LIMIT, wait_val);
      write_reg(CSR_COUNT_LIMIT, count_val);
      write_reg(CSR_SCALE, scale_val);
      write_reg(CSR_BETA, beta_val);
      write_reg(CSR_INIT_DIST, dist_val);
      // unmapped index, must not disturb anything
      write_reg(CSR_IDX_W'($urandom_range(CSR_FIRST_UNUSED, (1 << CSR_IDX_W) - 1)),
                DATA_W'($urandom));
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // one full ranging sequence; start and echo are random wherever they are ignored
   task automatic measure(input int low_ticks, input int high_ticks);
      send_tick(1'b1, 1'($urandom_range(0, 1)));
      while (sb.ph == PH_SETTLE || sb.ph == PH_PULSE)
         send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      repeat (low_ticks)
         if (sb.ph == PH_WAIT) send_tick(1'($urandom_range(0, 1)), 1'b0);
      while (sb.ph != PH_IDLE && high_ticks > 0) begin
         send_tick(1'($urandom_range(0, 1)), 1'b1);
         high_ticks--;
      end
      while (sb.ph != PH_IDLE) send_tick(1'($urandom_range(0, 1)), 1'b0);
   endtask

   initial begin
      int phase_no;
      int lo, hi;
      logic [DATA_W-1:0] beta_val;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: idle ticks, then a short echo with start and echo noise while triggering
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b1);
      while (sb.ph == PH_SETTLE || sb.ph == PH_PULSE) send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b0);
      repeat (5) send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
      drain();

      phase_no = 0;
      while (items_sent < ITEM_TARGET) begin
         idle_on = (phase_no % 3 != 2) && (items_sent < CALM_AFTER);
         case (phase_no)
            0: configure(16'd0, 16'd1, 16'd0, 16'd0, 16'd0);
            1: configure(16'd3, 16'd0, 16'hFFFF, DATA_W'(BETA_FULL), 16'h1234);
            2: configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd511, 16'hFFFF);
            3: configure(16'd5, 16'd2, SCALE_RST, 16'hFF2C, DATA_W'($urandom));
            default: begin
               beta_val = ($urandom_range(0, 5) == 0) ? DATA_W'($urandom_range(257, 511))
                                                      : DATA_W'($urandom_range(0, BETA_FULL));
               if ($urandom_range(0, 3) == 0)
                  beta_val = beta_val | DATA_W'($urandom & 32'hFE00);
               configure(DATA_W'($urandom_range(0, 20)),
                         DATA_W'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40)),
                         DATA_W'($urandom), beta_val, DATA_W'($urandom));
            end
         endcase
         if (phase_no == 1) long_hold_req = 1'b1;
         if (phase_no == 2) begin
            // long echo at full scale drives the distance into saturation
            measure(4, 1030);
         end else begin
            repeat ($urandom_range(1, 3)) begin
               if ($urandom_range(0, 3) == 0)
                  repeat ($urandom_range(1, 3)) send_tick(1'b0, 1'($urandom_range(0, 1)));
               lo = $urandom_range(0, (sb.wait_lim < 30) ? sb.wait_lim + 2 : 30);
               hi = $urandom_range(0, (sb.count_lim < 40) ? sb.count_lim + 2 : 40);
               if (hi == 0 && sb.wait_lim > 60) hi = 1;
               measure(lo, hi);
            end
         end
         drain();
         repeat ($urandom_range(0, 20)) @(posedge clock);
         phase_no++;
      end

      drain();
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("** ultrasonic_ranger_with_lowpass: PASSED **");
      else
         $display("** ultrasonic_ranger_with_lowpass: FAILED **");
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+sv
sv/ulr_pkg.sv
sv/ultrasonic_ranger_with_lowpass.sv
tb/testbench.sv
